// File: rtl/mws_pkg.sv
// Shared constants and types for the minimum window substring unit.
package mws_pkg;

  // Sizes
  localparam int unsigned MaxText  = 1024;
  localparam int unsigned Alphabet = 128;
  localparam int unsigned SymW     = 7;
  localparam int unsigned TextAw   = $clog2(MaxText);
  localparam int unsigned TextCntW = TextAw + 1;
  localparam int unsigned AlphaAw  = $clog2(Alphabet);
  localparam int unsigned NeedW    = 12;
  localparam int unsigned MissW    = 11;
  localparam logic [MissW-1:0] MissCap = {MissW{1'b1}};

  // Request opcodes
  localparam logic OpPattern = 1'b0;
  localparam logic OpText    = 1'b1;

  typedef struct packed {
    logic            op;
    logic [SymW-1:0] symbol;
    logic            last;
  } req_t;

  typedef struct packed {
    logic            found;
    logic [9:0]      start_res;
    logic [10:0]     length;
    logic            overflow;
  } res_t;

  // One entry of the need table
  typedef struct packed {
    logic                    wanted;
    logic signed [NeedW-1:0] need;
  } tbl_entry_t;

  // Write request into the need table
  typedef struct packed {
    logic               we;
    logic [AlphaAw-1:0] addr;
    tbl_entry_t         entry;
  } tbl_wr_t;

endpackage

// File: rtl/minimum_window_substring_unit.sv
// Top level: sequencer for the minimum window substring search.
//
// Usage: a request is taken when start is high and busy is low. op selects
// pattern load or text feed; last marks the final text character of a job.
// Load the pattern characters first, then stream the text.
// A pattern request reads the need table, then writes the entry back.
// A text request reads the need table and writes it back; each step of the left
// edge then does a text buffer read, a need table read and a need table write
// back, all through the single read port of each memory. Each text character
// moves the left edge at most once per job.
// On the last text character the result is presented on res_o for exactly
// one cycle with res_valid_o high, in the cycle after its processing ends; the
// receiver cannot stall it. In the same cycle all job state is cleared and
// the need table is invalidated at once, so no clearing pass is needed.
// Text beyond the buffer capacity is dropped and flagged in overflow.
// Reset is asynchronous and leaves the block idle with an empty job.
module minimum_window_substring_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  mws_pkg::req_t req_i,
  output logic          res_valid_o,
  output mws_pkg::res_t res_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAT,
    S_TXT,
    S_L0,
    S_L1,
    S_L2
  } state_e;

  state_e                          state_q, state_d;
  logic [mws_pkg::SymW-1:0]        sym_q, sym_d;
  logic                            last_q, last_d;
  logic                            took_q, took_d;
  logic [mws_pkg::SymW-1:0]        c_q, c_d;
  logic [mws_pkg::MissW-1:0]       missing_q, missing_d;
  logic [mws_pkg::TextAw-1:0]      left_q, left_d;
  logic [mws_pkg::TextCntW-1:0]    right_q, right_d;
  logic [mws_pkg::TextAw-1:0]      best_start_q, best_start_d;
  logic [mws_pkg::TextCntW-1:0]    best_len_q, best_len_d;
  logic                            best_valid_q, best_valid_d;
  logic                            ovf_q, ovf_d;
  logic                            res_valid_q, res_valid_d;
  mws_pkg::res_t                   res_q, res_d;

  logic                            accept;
  logic                            clear;
  logic [mws_pkg::AlphaAw-1:0]     tbl_rd_addr;
  mws_pkg::tbl_wr_t                tbl_wr;
  mws_pkg::tbl_entry_t             tbl_rd;
  logic                            txt_we;
  logic [mws_pkg::SymW-1:0]        txt_rdata;
  logic signed [mws_pkg::NeedW-1:0] need_new;
  logic [mws_pkg::MissW-1:0]       miss_new;
  logic [mws_pkg::TextCntW-1:0]    win_len;
  logic [mws_pkg::TextCntW-1:0]    left_next;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign txt_we = accept && (req_i.op == mws_pkg::OpText) &&
                  (right_q < mws_pkg::TextCntW'(mws_pkg::MaxText));
  assign win_len   = right_q - {1'b0, left_q};
  assign left_next = {1'b0, left_q} + mws_pkg::TextCntW'(1);

  // Memories
  mws_need_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (clear),
    .rd_addr_i (tbl_rd_addr),
    .wr_i      (tbl_wr),
    .rd_data_o (tbl_rd)
  );

  mws_text_buf u_text (
    .clk_i   (clk_i),
    .we_i    (txt_we),
    .waddr_i (right_q[mws_pkg::TextAw-1:0]),
    .wdata_i (req_i.symbol),
    .raddr_i (left_q),
    .rdata_o (txt_rdata)
  );

  // Sequencer
  always_comb begin
    state_d      = state_q;
    sym_d        = sym_q;
    last_d       = last_q;
    took_d       = took_q;
    c_d          = c_q;
    missing_d    = missing_q;
    left_d       = left_q;
    right_d      = right_q;
    best_start_d = best_start_q;
    best_len_d   = best_len_q;
    best_valid_d = best_valid_q;
    ovf_d        = ovf_q;
    res_valid_d  = 1'b0;
    res_d        = res_q;
    clear        = 1'b0;
    tbl_rd_addr  = sym_q;
    tbl_wr       = '0;
    need_new     = '0;
    miss_new     = missing_q;

    case (state_q)
      S_IDLE: begin
        tbl_rd_addr = req_i.symbol;
        if (accept) begin
          sym_d  = req_i.symbol;
          last_d = req_i.last;
          if (req_i.op == mws_pkg::OpPattern) begin
            state_d = S_PAT;
          end else begin
            state_d = S_TXT;
            took_d  = txt_we;
            if (txt_we) begin
              right_d = right_q + mws_pkg::TextCntW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
        end
      end

      // Pattern character: raise need, mark wanted
      S_PAT: begin
        need_new = tbl_rd.need + mws_pkg::NeedW'(1);
        if (missing_q < mws_pkg::MissCap) begin
          tbl_wr.we           = 1'b1;
          tbl_wr.addr         = sym_q;
          tbl_wr.entry.wanted = 1'b1;
          tbl_wr.entry.need   = need_new;
          if (!need_new[mws_pkg::NeedW-1] && (need_new != '0)) begin
            missing_d = missing_q + mws_pkg::MissW'(1);
          end
        end
        state_d = S_IDLE;
      end

      // Text character: lower need, maybe start shrinking
      S_TXT: begin
        need_new = tbl_rd.need - mws_pkg::NeedW'(1);
        state_d  = S_IDLE;
        if (took_q && tbl_rd.wanted) begin
          tbl_wr.we           = 1'b1;
          tbl_wr.addr         = sym_q;
          tbl_wr.entry.wanted = 1'b1;
          tbl_wr.entry.need   = need_new;
          if (!need_new[mws_pkg::NeedW-1] && (missing_q != '0)) begin
            miss_new = missing_q - mws_pkg::MissW'(1);
          end
          missing_d = miss_new;
          if ((miss_new == '0) && ({1'b0, left_q} < right_q)) begin
            state_d = S_L0;
          end
        end
      end

      // Wait for text buffer read at the left edge
      S_L0: begin
        state_d = S_L1;
      end

      // Record window, look up the leaving character
      S_L1: begin
        tbl_rd_addr = txt_rdata;
        c_d         = txt_rdata;
        if (!best_valid_q || (win_len < best_len_q)) begin
          best_valid_d = 1'b1;
          best_len_d   = win_len;
          best_start_d = left_q;
        end
        state_d = S_L2;
      end

      // Give the leaving character back, step the left edge
      S_L2: begin
        need_new = tbl_rd.need + mws_pkg::NeedW'(1);
        if (tbl_rd.wanted) begin
          tbl_wr.we           = 1'b1;
          tbl_wr.addr         = c_q;
          tbl_wr.entry.wanted = 1'b1;
          tbl_wr.entry.need   = need_new;
          if (!need_new[mws_pkg::NeedW-1] && (need_new != '0)) begin
            miss_new = missing_q + mws_pkg::MissW'(1);
          end
        end
        missing_d = miss_new;
        left_d    = left_next[mws_pkg::TextAw-1:0];
        if ((miss_new == '0) && (left_next < right_q)) begin
          state_d = S_L0;
        end else begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // End of a text request: report on last and clear the job
    if ((state_q != S_IDLE) && (state_q != S_PAT) && (state_d == S_IDLE) && last_q) begin
      res_valid_d     = 1'b1;
      res_d.found     = best_valid_d;
      res_d.start_res = best_valid_d ? best_start_d : '0;
      res_d.length    = best_valid_d ? best_len_d : '0;
      res_d.overflow  = ovf_d;
      clear           = 1'b1;
      missing_d       = '0;
      left_d          = '0;
      right_d         = '0;
      best_start_d    = '0;
      best_len_d      = '0;
      best_valid_d    = 1'b0;
      ovf_d           = 1'b0;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      sym_q        <= '0;
      last_q       <= 1'b0;
      took_q       <= 1'b0;
      c_q          <= '0;
      missing_q    <= '0;
      left_q       <= '0;
      right_q      <= '0;
      best_start_q <= '0;
      best_len_q   <= '0;
      best_valid_q <= 1'b0;
      ovf_q        <= 1'b0;
      res_valid_q  <= 1'b0;
      res_q        <= '0;
    end else begin
      state_q      <= state_d;
      sym_q        <= sym_d;
      last_q       <= last_d;
      took_q       <= took_d;
      c_q          <= c_d;
      missing_q    <= missing_d;
      left_q       <= left_d;
      right_q      <= right_d;
      best_start_q <= best_start_d;
      best_len_q   <= best_len_d;
      best_valid_q <= best_valid_d;
      ovf_q        <= ovf_d;
      res_valid_q  <= res_valid_d;
      res_q        <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Checks
  a_cleared_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (missing_q == '0) && !best_valid_q && (right_q == '0))
    else $error("job state not cleared with result");

  a_left_within_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, left_q} <= right_q)
    else $error("left edge passed right edge");

  a_found_has_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.found) |-> (res_o.length != '0))
    else $error("found result with zero length");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy && $past(last_q))
    else $error("result outside end of a text request");

endmodule

// File: rtl/mws_need_table.sv
// Need/wanted table: synchronous memory with per-entry valid bits for a clear of all entries at once.
module mws_need_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clear_i,
  input  logic [mws_pkg::AlphaAw-1:0] rd_addr_i,
  input  mws_pkg::tbl_wr_t            wr_i,
  output mws_pkg::tbl_entry_t         rd_data_o
);

  mws_pkg::tbl_entry_t mem [mws_pkg::Alphabet];
  mws_pkg::tbl_entry_t mem_q;
  logic [mws_pkg::Alphabet-1:0] valid_q;
  logic                         rd_valid_q;

  // Storage and registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.entry;
    end
    mem_q <= mem[rd_addr_i];
  end

  // Valid bits: an entry never written since the last clear reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[rd_addr_i];
      if (clear_i) begin
        valid_q <= '0;
      end else if (wr_i.we) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_valid_q ? mem_q : '0;

endmodule

// File: rtl/mws_text_buf.sv
// Text buffer: one write port, one registered read port.
module mws_text_buf (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [mws_pkg::TextAw-1:0] waddr_i,
  input  logic [mws_pkg::SymW-1:0]   wdata_i,
  input  logic [mws_pkg::TextAw-1:0] raddr_i,
  output logic [mws_pkg::SymW-1:0]   rdata_o
);

  logic [mws_pkg::SymW-1:0] mem [mws_pkg::MaxText];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the minimum window substring unit.
`timescale 1ns / 1ps

module tb_top;
  import mws_pkg::*;

  localparam int Limit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  req_t req_i = '0;
  logic busy;
  logic res_valid_o;
  res_t res_o;

  minimum_window_substring_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Window tracker state, mirrors one job of the block
  int              need_tab [Alphabet];
  bit              want_tab [Alphabet];
  logic [SymW-1:0] text_buf [MaxText];
  int unsigned     miss_cnt, left_pos, right_pos, best_pos, best_len;
  bit              best_ok, spilled;

  res_t windows_due [$];
  int   mismatches = 0;
  int   sent_reqs = 0;
  int   burst_left = 1;

  function automatic void clear_job();
    foreach (need_tab[i]) begin
      need_tab[i] = 0;
      want_tab[i] = 1'b0;
    end
    miss_cnt = 0;
    left_pos = 0;
    right_pos = 0;
    best_pos = 0;
    best_len = 0;
    best_ok = 1'b0;
    spilled = 1'b0;
  endfunction

  // Advance the tracker by one request; returns 1 when a window result is due
  function automatic bit track_request(input req_t rq, output res_t win);
    int unsigned rpos;
    logic [SymW-1:0] c;
    win = '0;
    if (rq.op == OpPattern) begin
      if (miss_cnt < MissCap) begin
        want_tab[rq.symbol] = 1'b1;
        need_tab[rq.symbol]++;
        if (need_tab[rq.symbol] > 0) miss_cnt++;
      end
      return 1'b0;
    end
    if (right_pos < MaxText) begin
      rpos = right_pos;
      text_buf[rpos] = rq.symbol;
      right_pos++;
      if (want_tab[rq.symbol]) begin
        need_tab[rq.symbol]--;
        if (need_tab[rq.symbol] >= 0 && miss_cnt > 0) miss_cnt--;
        // shrink from the left while the window still covers the pattern
        while (miss_cnt == 0 && left_pos <= rpos) begin
          if (!best_ok || (rpos - left_pos + 1) < best_len) begin
            best_ok = 1'b1;
            best_len = rpos - left_pos + 1;
            best_pos = left_pos;
          end
          c = text_buf[left_pos];
          if (want_tab[c]) begin
            need_tab[c]++;
            if (need_tab[c] > 0) miss_cnt++;
          end
          left_pos++;
        end
      end
    end else begin
      spilled = 1'b1;
    end
    if (!rq.last) return 1'b0;
    win.found = best_ok;
    win.start_res = best_ok ? best_pos[9:0] : 10'd0;
    win.length = best_ok ? best_len[10:0] : 11'd0;
    win.overflow = spilled;
    clear_job();
    return 1'b1;
  endfunction

  // Drive one request at the falling edge, hold it until taken
  task automatic send_req(input logic op, input logic [SymW-1:0] sym, input logic lst,
                          input bit typed, input res_t typed_res);
    req_t rq;
    res_t win;
    bit due;
    rq.op = op;
    rq.symbol = sym;
    rq.last = lst;
    start <= 1'b1;
    req_i <= rq;
    do @(posedge clk_i); while (busy);
    due = track_request(rq, win);
    if (due) windows_due.push_back(typed ? typed_res : win);
    sent_reqs++;
    @(negedge clk_i);
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 40);
    end
  endtask

  // Hold off the sender until every due window has come back
  task automatic drain_windows();
    start <= 1'b0;
    while (windows_due.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [SymW-1:0] other_sym(input logic [SymW-1:0] a,
                                                input logic [SymW-1:0] b);
    logic [SymW-1:0] s;
    do s = SymW'($urandom_range(0, Alphabet - 1)); while (s == a || s == b);
    return s;
  endfunction

  // Short job over a tiny random alphabet, or a burst of noise
  task automatic random_job();
    logic [SymW-1:0] abc [4];
    int plen, tlen;
    foreach (abc[i]) abc[i] = SymW'($urandom_range(0, Alphabet - 1));
    if ($urandom_range(0, 11) == 0) begin
      repeat ($urandom_range(1, 8))
        send_req(1'($urandom_range(0, 1)), SymW'($urandom), 1'($urandom_range(0, 1)),
                 1'b0, '0);
      return;
    end
    plen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
    tlen = $urandom_range(1, 24);
    repeat (plen)
      send_req(OpPattern, abc[$urandom_range(0, 3)], $urandom_range(0, 9) == 0, 1'b0, '0);
    for (int i = 0; i < tlen; i++) begin
      // a pattern request in the middle of the text now and then
      if ($urandom_range(0, 19) == 0)
        send_req(OpPattern, abc[$urandom_range(0, 3)], 1'($urandom_range(0, 1)), 1'b0, '0);
      send_req(OpText,
               ($urandom_range(0, 9) == 0) ? SymW'($urandom) : abc[$urandom_range(0, 3)],
               i == tlen - 1, 1'b0, '0);
    end
  endtask

  // Full buffer: closing symbol at the last slot, optional head at slot 0, optional spill
  task automatic span_job(input bit head, input bit spill);
    logic [SymW-1:0] p1, p2;
    int n;
    p1 = SymW'($urandom_range(0, Alphabet - 1));
    do p2 = SymW'($urandom_range(0, Alphabet - 1)); while (p2 == p1);
    n = spill ? MaxText + 6 : MaxText;
    if (head) send_req(OpPattern, p1, 1'b0, 1'b0, '0);
    send_req(OpPattern, p2, 1'b0, 1'b0, '0);
    for (int i = 0; i < n; i++)
      send_req(OpText,
               (head && i == 0) ? p1 : (i == MaxText - 1) ? p2 : other_sym(p1, p2),
               i == n - 1, 1'b0, '0);
  endtask

  // Pattern longer than the missing counter can hold
  task automatic cap_job();
    logic [SymW-1:0] abc [3];
    foreach (abc[i]) abc[i] = SymW'($urandom_range(0, Alphabet - 1));
    repeat (int'(MissCap) + 13) send_req(OpPattern, abc[$urandom_range(0, 2)], 1'b0, 1'b0, '0);
    for (int i = 0; i < 40; i++)
      send_req(OpText, abc[$urandom_range(0, 2)], i == 39, 1'b0, '0);
  endtask

  // Directed requests; typed rows carry a hand-written window
  typedef struct {
    logic            op;
    logic [SymW-1:0] sym;
    logic            last;
    bit              typed;
    res_t            win;
  } dir_row_t;

  localparam res_t NotFound = '0;
  localparam res_t OneAtZero = '{found: 1'b1, start_res: 10'd0, length: 11'd1,
                                 overflow: 1'b0};

  dir_row_t dir_tab [24] = '{
    '{OpText,    7'h61, 1'b1, 1'b1, NotFound},   // empty pattern
    '{OpPattern, 7'h61, 1'b0, 1'b0, NotFound},
    '{OpText,    7'h61, 1'b1, 1'b1, OneAtZero},
    '{OpPattern, 7'h00, 1'b0, 1'b0, NotFound},   // lowest and highest codes
    '{OpPattern, 7'h7f, 1'b0, 1'b0, NotFound},
    '{OpText,    7'h7f, 1'b0, 1'b0, NotFound},
    '{OpText,    7'h00, 1'b0, 1'b0, NotFound},
    '{OpText,    7'h05, 1'b0, 1'b0, NotFound},
    '{OpText,    7'h7f, 1'b1, 1'b0, NotFound},
    '{OpPattern, 7'h2a, 1'b1, 1'b0, NotFound},   // last on a pattern request
    '{OpPattern, 7'h62, 1'b0, 1'b0, NotFound},   // repeated symbol
    '{OpPattern, 7'h62, 1'b0, 1'b0, NotFound},
    '{OpText,    7'h62, 1'b0, 1'b0, NotFound},
    '{OpText,    7'h2a, 1'b0, 1'b0, NotFound},
    '{OpText,    7'h55, 1'b0, 1'b0, NotFound},
    '{OpText,    7'h62, 1'b1, 1'b0, NotFound},
    '{OpPattern, 7'h63, 1'b0, 1'b0, NotFound},   // nothing matches
    '{OpText,    7'h64, 1'b1, 1'b1, NotFound},
    '{OpText,    7'h65, 1'b0, 1'b0, NotFound},   // pattern after text
    '{OpPattern, 7'h65, 1'b0, 1'b0, NotFound},
    '{OpText,    7'h65, 1'b0, 1'b0, NotFound},
    '{OpPattern, 7'h66, 1'b0, 1'b0, NotFound},
    '{OpText,    7'h66, 1'b0, 1'b0, NotFound},
    '{OpText,    7'h65, 1'b1, 1'b0, NotFound}
  };

  // Result checker
  always @(posedge clk_i) begin : check_windows
    res_t want;
    if (rst_ni && res_valid_o) begin
      if (windows_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: found=%0d start=%0d len=%0d ovf=%0d",
                   res_o.found, res_o.start_res, res_o.length, res_o.overflow);
      end else begin
        want = windows_due.pop_front();
        if (res_o.found !== want.found || res_o.start_res !== want.start_res ||
            res_o.length !== want.length || res_o.overflow !== want.overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp found=%0d start=%0d len=%0d ovf=%0d, got %0d %0d %0d %0d",
                     want.found, want.start_res, want.length, want.overflow,
                     res_o.found, res_o.start_res, res_o.length, res_o.overflow);
        end
      end
    end
  end

  // Watchdog on cycles with no request taken and no result
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((start && !busy) || res_valid_o) quiet = 0;
      else quiet++;
      if (quiet >= Limit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    clear_job();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i])
      send_req(dir_tab[i].op, dir_tab[i].sym, dir_tab[i].last, dir_tab[i].typed,
               dir_tab[i].win);
    drain_windows();

    while (sent_reqs < 1250 + $size(dir_tab)) begin
      random_job();
      if ($urandom_range(0, 99) == 0) drain_windows();
    end

    drain_windows();
    span_job(1'b1, 1'b1);
    span_job(1'b0, 1'b0);
    cap_job();
    repeat (20) random_job();

    drain_windows();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && windows_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/mws_pkg.sv
rtl/mws_need_table.sv
rtl/mws_text_buf.sv
rtl/minimum_window_substring_unit.sv
bench/tb_top.sv
